[sv/uct_pkg.sv]
package uct_pkg;

   localparam int KwCount = 19;
   localparam int CharW   = 8;
   localparam int LenW    = 8;
   localparam int TypeW   = 5;
   localparam int SlashW  = 4;

   localparam logic [LenW-1:0]   MAX_LENGTH = 8'd255;
   localparam logic [SlashW-1:0] SLASH_MAX  = 4'd15;

   localparam logic [TypeW-1:0] TYPE_MOVE    = 5'd19;
   localparam logic [TypeW-1:0] TYPE_FENBODY = 5'd20;
   localparam logic [TypeW-1:0] TYPE_INT     = 5'd21;
   localparam logic [TypeW-1:0] TYPE_WORD    = 5'd22;
   localparam logic [TypeW-1:0] TYPE_END     = 5'd23;
   localparam logic [TypeW-1:0] TYPE_UNKNOWN = 5'd24;

   localparam logic [CharW-1:0] CH_SPACE = 8'h20;
   localparam logic [CharW-1:0] CH_SLASH = 8'h2F;
   localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
   localparam logic [CharW-1:0] CH_LF    = 8'h0A;
   localparam logic [CharW-1:0] CH_CR    = 8'h0D;

   // keyword text, right justified, first character in the highest used byte
   localparam logic [79:0] KW_TEXT [KwCount] = '{
      80'("position"), 80'("moves"), 80'("uci"), 80'("go"), 80'("quit"),
      80'("isready"), 80'("setoption"), 80'("ucinewgame"), 80'("stop"),
      80'("startpos"), 80'("-"), 80'("depth"), 80'("wtime"), 80'("btime"),
      80'("winc"), 80'("binc"), 80'("perft"), 80'("fen"), 80'("d")
   };

   localparam logic [3:0] KW_LEN [KwCount] = '{
      4'd8, 4'd5, 4'd3, 4'd2, 4'd4, 4'd7, 4'd9, 4'd10, 4'd4,
      4'd8, 4'd1, 4'd5, 4'd5, 4'd5, 4'd4, 4'd4, 4'd5, 4'd3, 4'd1
   };

   typedef struct packed {
      logic [KwCount-1:0] alive;
      logic [LenW-1:0]    count;
      logic [SlashW-1:0]  slash;
      logic               digits;
      logic               letters;
      logic               move_ok;
      logic               zero_ok;
      logic               le_first;
   } tok_state_type;

   localparam tok_state_type TOK_RESET = '{
      alive:    {KwCount{1'b1}},
      count:    '0,
      slash:    '0,
      digits:   1'b1,
      letters:  1'b1,
      move_ok:  1'b1,
      zero_ok:  1'b1,
      le_first: 1'b0
   };

   typedef struct packed {
      logic [TypeW-1:0] tok_type;
      logic [LenW-1:0]  tok_len;
      logic             with_end;   // end-of-line result follows the token
   } rsp_entry_type;

   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);

   function automatic logic [CharW-1:0] kw_char(input int k, input logic [3:0] pos);
      logic [79:0] t;
      logic [3:0]  sh;
      t  = KW_TEXT[k];
      sh = KW_LEN[k] - 4'd1 - pos;
      return CharW'(t >> {sh, 3'b000});
   endfunction

endpackage

[sv/uci_command_token_classifier.sv]
// A request that ends a token pushes its result into the queue that feeds the output.
// One request per cycle while req_ready is high; a line end yields two results in turn.
// Results wait in a four-entry queue; req_ready drops only while that queue is full.
// Reset (synchronous, active high) restores the token state, clears the queue and the
// output sequencer; no result is valid in the cycle after reset.
module uci_command_token_classifier import uct_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [CharW-1:0] req_char_code,
   input  logic             req_end_of_input,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [TypeW-1:0] rsp_token_type,
   output logic [LenW-1:0]  rsp_token_length,
   output logic             rsp_end_marker
);

   rsp_entry_type push_entry;
   rsp_entry_type head_entry;
   logic          push;
   logic          pop;
   logic          q_full;
   logic          q_not_empty;

   uct_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_end_of_input (req_end_of_input),
      .q_full           (q_full),
      .q_push           (push),
      .q_entry          (push_entry)
   );

   uct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_entry (head_entry),
      .not_empty  (q_not_empty)
   );

   uct_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_entry       (head_entry),
      .not_empty        (q_not_empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_type   (rsp_token_type),
      .rsp_token_length (rsp_token_length),
      .rsp_end_marker   (rsp_end_marker)
   );

endmodule

[sv/uct_front.sv]
module uct_front import uct_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CharW-1:0]    req_char_code,
   input  logic                req_end_of_input,
   input  logic                q_full,
   output logic                q_push,
   output rsp_entry_type       q_entry
);

   tok_state_type tok_ff, tok_in;
   tok_state_type nxt;
   logic          accept;
   logic          is_space;

   function automatic logic is_digit(input logic [CharW-1:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_letter(input logic [CharW-1:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

   function automatic logic is_promo(input logic [CharW-1:0] c);
      return c == 8'h51 || c == 8'h71 || c == 8'h4E || c == 8'h6E ||
             c == 8'h42 || c == 8'h62 || c == 8'h52 || c == 8'h72;
   endfunction

   function automatic logic [TypeW-1:0] classify(input tok_state_type s);
      logic [TypeW-1:0] res;
      logic             found;
      res   = TYPE_UNKNOWN;
      found = 1'b0;
      for (int k = 0; k < KwCount; k++) begin
         if (!found && s.alive[k] && s.count == {4'd0, KW_LEN[k]}) begin
            res   = TypeW'(k);
            found = 1'b1;
         end
      end
      if (!found) begin
         if ((s.count == 8'd4 && s.zero_ok) ||
             ((s.count == 8'd4 || s.count == 8'd5) && s.move_ok))
            res = TYPE_MOVE;
         else if (s.slash == 4'd7)
            res = TYPE_FENBODY;
         else if (s.digits)
            res = TYPE_INT;
         else if (s.letters)
            res = TYPE_WORD;
         else if (s.le_first && s.count == 8'd1)
            res = TYPE_END;
         else
            res = TYPE_UNKNOWN;
      end
      return res;
   endfunction

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign is_space  = req_char_code == CH_SPACE;

   // token state after taking in this character
   always_comb begin
      logic [LenW-1:0] p;
      p   = tok_ff.count;
      nxt = tok_ff;
      for (int k = 0; k < KwCount; k++) begin
         nxt.alive[k] = tok_ff.alive[k] && (p < {4'd0, KW_LEN[k]}) &&
                        (kw_char(k, p[3:0]) == req_char_code);
      end
      if (req_char_code == CH_SLASH && tok_ff.slash != SLASH_MAX)
         nxt.slash = tok_ff.slash + 4'd1;
      nxt.digits  = tok_ff.digits && is_digit(req_char_code);
      nxt.letters = tok_ff.letters && is_letter(req_char_code);
      if (p < 8'd4) begin
         if (p[0])
            nxt.move_ok = tok_ff.move_ok && is_digit(req_char_code);
         else
            nxt.move_ok = tok_ff.move_ok && is_letter(req_char_code);
      end else if (p == 8'd4) begin
         nxt.move_ok = tok_ff.move_ok && is_promo(req_char_code);
      end else begin
         nxt.move_ok = 1'b0;
      end
      nxt.zero_ok  = tok_ff.zero_ok && (p < 8'd4) && (req_char_code == CH_ZERO);
      nxt.le_first = (p == '0) && (req_char_code == CH_LF || req_char_code == CH_CR);
      if (tok_ff.count != MAX_LENGTH)
         nxt.count = tok_ff.count + 8'd1;
   end

   // a space reports the token as it stands; a last non-space byte is absorbed first
   always_comb begin
      q_push           = accept && (is_space || req_end_of_input);
      q_entry.with_end = req_end_of_input;
      if (is_space) begin
         q_entry.tok_type = classify(tok_ff);
         q_entry.tok_len  = tok_ff.count;
      end else begin
         q_entry.tok_type = classify(nxt);
         q_entry.tok_len  = nxt.count;
      end
      tok_in = tok_ff;
      if (accept)
         tok_in = (is_space || req_end_of_input) ? TOK_RESET : nxt;
   end

   always_ff @(posedge clock) begin
      if (reset)
         tok_ff <= TOK_RESET;
      else
         tok_ff <= tok_in;
   end

endmodule

[sv/uct_queue.sv]
module uct_queue import uct_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  rsp_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output rsp_entry_type head_entry,
   output logic          not_empty
);

   rsp_entry_type         slot_ff [QDepth];
   logic [QPtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QPtrW:0]        fill_ff, fill_in;

   assign full       = fill_ff == (QPtrW+1)'(QDepth);
   assign not_empty  = fill_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop)
         fill_in = fill_ff + 1'b1;
      else if (pop && !push)
         fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

[sv/uct_back.sv]
module uct_back import uct_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  rsp_entry_type    head_entry,
   input  logic             not_empty,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [TypeW-1:0] rsp_token_type,
   output logic [LenW-1:0]  rsp_token_length,
   output logic             rsp_end_marker
);

   // set while the end-of-line result of the head entry is pending
   logic end_phase_ff, end_phase_in;
   logic take;

   assign rsp_valid = not_empty;
   assign take      = rsp_valid && rsp_ready;

   always_comb begin
      if (end_phase_ff) begin
         rsp_token_type   = TYPE_END;
         rsp_token_length = '0;
         rsp_end_marker   = 1'b1;
      end else begin
         rsp_token_type   = head_entry.tok_type;
         rsp_token_length = head_entry.tok_len;
         rsp_end_marker   = 1'b0;
      end
      pop          = 1'b0;
      end_phase_in = end_phase_ff;
      if (take) begin
         if (!end_phase_ff && head_entry.with_end) begin
            end_phase_in = 1'b1;
         end else begin
            pop          = 1'b1;
            end_phase_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         end_phase_ff <= 1'b0;
      else
         end_phase_ff <= end_phase_in;
   end

endmodule

[sv/uct_checker.sv]
module uct_checker import uct_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [TypeW-1:0] rsp_token_type,
   input logic [LenW-1:0]  rsp_token_length,
   input logic             rsp_end_marker
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_type) &&
      $stable(rsp_token_length) && $stable(rsp_end_marker))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_end_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_marker |-> rsp_token_type == TYPE_END && rsp_token_length == '0)
      else $error("end marker on a non-end result");

   a_type_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_token_type <= TYPE_UNKNOWN)
      else $error("token type out of range");

   a_line_break_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_type == TYPE_END && !rsp_end_marker |-> rsp_token_length == 8'd1)
      else $error("line break token with wrong length");

endmodule

bind uci_command_token_classifier uct_checker u_uct_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_token_type   (rsp_token_type),
   .rsp_token_length (rsp_token_length),
   .rsp_end_marker   (rsp_end_marker)
);
